// File: design/csi_pkg.sv
// Shared constants and types for the circle / segment intersection pipeline.
// No dependencies; used by circle_segment_intersection.
package csi_pkg;

  // coordinate width and derived internal widths
  localparam int CW   = 16;
  localparam int UW   = CW + 1;        // coordinate differences
  localparam int RW   = CW - 1;        // radius
  localparam int RRW  = 2 * RW;        // radius squared
  localparam int DW   = 2 * UW;        // squared length d
  localparam int DLW  = DW / 2;        // low split of d for r*r*d
  localparam int DHW  = DW - DLW;      // high split of d
  localparam int CRW  = 2 * UW + 1;    // cross term D
  localparam int SQW  = 32;            // square root width
  localparam int DISW = 2 * SQW;       // discriminant width
  localparam int REMW = SQW + 3;       // square root remainder
  localparam int PW   = 56;            // box test products

  // sideband that follows each word through the square root
  typedef struct packed {
    logic signed [UW-1:0]  ux;
    logic signed [UW-1:0]  uy;
    logic signed [UW-1:0]  xlo;
    logic signed [UW-1:0]  xhi;
    logic signed [UW-1:0]  ylo;
    logic signed [UW-1:0]  yhi;
    logic [DW-1:0]         d;
    logic signed [CRW-1:0] dc;
    logic                  meets;
    logic                  nz;
  } side_t;

  // one square root stage
  typedef struct packed {
    logic [DISW-1:0] disc;
    logic [REMW-1:0] rem;
    logic [SQW-1:0]  root;
    side_t           sb;
  } sq_t;

endpackage

// File: design/circle_segment_intersection.sv
// Throughput: one word per cycle while no result word is held by out_stall;
// the 32-stage square root sets the depth.
// Every stage advances together unless a valid result word is held by
// out_stall. Synchronous active-low reset clears all valid bits; data
// registers are not reset.
// Depends on csi_pkg.
module circle_segment_intersection (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [csi_pkg::CW-1:0] in_end_a_x,
  input  logic signed [csi_pkg::CW-1:0] in_end_a_y,
  input  logic signed [csi_pkg::CW-1:0] in_end_b_x,
  input  logic signed [csi_pkg::CW-1:0] in_end_b_y,
  input  logic signed [csi_pkg::CW-1:0] in_center_x,
  input  logic signed [csi_pkg::CW-1:0] in_center_y,
  input  logic [csi_pkg::RW-1:0]        in_circle_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic                          out_line_meets_circle
);

  localparam int UW   = csi_pkg::UW;
  localparam int DW   = csi_pkg::DW;
  localparam int DLW  = csi_pkg::DLW;
  localparam int DHW  = csi_pkg::DHW;
  localparam int CRW  = csi_pkg::CRW;
  localparam int RW   = csi_pkg::RW;
  localparam int RRW  = csi_pkg::RRW;
  localparam int SQW  = csi_pkg::SQW;
  localparam int DISW = csi_pkg::DISW;
  localparam int REMW = csi_pkg::REMW;
  localparam int PW   = csi_pkg::PW;
  localparam int MW   = RRW + DHW;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: differences and box edges relative to center
  logic                 v1_r;
  logic signed [UW-1:0] ux1_r, uy1_r, pax1_r, pay1_r, pbx1_r, pby1_r;
  logic signed [UW-1:0] xlo1_r, xhi1_r, ylo1_r, yhi1_r;
  logic [RW-1:0]        r1_r;
  // stage 2: products
  logic                   v2_r;
  logic [DW-1:0]          uxx2_r, uyy2_r;
  logic signed [CRW-1:0]  c12_r, c22_r;
  logic [RRW-1:0]         rr2_r;
  csi_pkg::side_t         sb2_r;
  // stage 3: d, D
  logic                   v3_r;
  logic [RRW-1:0]         rr3_r;
  csi_pkg::side_t         sb3_r;
  // stage 4: |D|^2 and split r*r*d
  logic                   v4_r, small4_r;
  logic [DISW-1:0]        dd4_r;
  logic [MW-1:0]          plo4_r, phi4_r;
  csi_pkg::side_t         sb4_r;
  // stage 5: r*r*d
  logic                   v5_r, small5_r;
  logic [DISW-1:0]        dd5_r, rrd5_r;
  csi_pkg::side_t         sb5_r;
  // square root pipe
  logic [SQW:0]           sqv_r;
  csi_pkg::sq_t           sq_r [SQW+1];
  // post stages
  logic                   t1v_r, t2v_r;
  logic signed [PW-1:0]   uxs1_r, auys1_r, bxp1_r, dcux1_r;
  logic signed [PW-1:0]   dxlo1_r, dxhi1_r, dylo1_r, dyhi1_r;
  logic                   uyneg1_r, flag1_r, meets1_r;
  logic signed [PW-1:0]   n1x2_r, n1y2_r, n2x2_r, n2y2_r;
  logic signed [PW-1:0]   dxlo2_r, dxhi2_r, dylo2_r, dyhi2_r;
  logic                   flag2_r, meets2_r;
  logic                   ov_r, ohit_r, omeet_r;

  // combinational helpers
  logic signed [UW-1:0]  ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
  logic [CRW-1:0]        dabs;
  logic signed [PW-1:0]  ox, oy, by2;
  logic                  in1, in2;
  logic [DISW-1:0]       disc6;
  logic                  meets6;
  csi_pkg::side_t        sb2_nxt, sb3_nxt, sb4_nxt;
  csi_pkg::sq_t          sq0_nxt;

  always_comb begin
    ax_e = UW'(in_end_a_x);
    ay_e = UW'(in_end_a_y);
    bx_e = UW'(in_end_b_x);
    by_e = UW'(in_end_b_y);
    cx_e = UW'(in_center_x);
    cy_e = UW'(in_center_y);
    dabs = sb3_r.dc[CRW-1] ? CRW'(-sb3_r.dc) : CRW'(sb3_r.dc);
    meets6 = small5_r && (dd5_r <= rrd5_r);
    disc6  = meets6 ? (rrd5_r - dd5_r) : '0;
    ox  = uyneg1_r ? -uxs1_r : uxs1_r;
    oy  = auys1_r;
    by2 = -dcux1_r;
    in1 = (n1x2_r > dxlo2_r) && (n1x2_r < dxhi2_r) &&
          (n1y2_r > dylo2_r) && (n1y2_r < dyhi2_r);
    in2 = (n2x2_r > dxlo2_r) && (n2x2_r < dxhi2_r) &&
          (n2y2_r > dylo2_r) && (n2y2_r < dyhi2_r);
    // sideband for each stage that fills in a field
    sb2_nxt     = '0;
    sb2_nxt.ux  = ux1_r;
    sb2_nxt.uy  = uy1_r;
    sb2_nxt.xlo = xlo1_r;
    sb2_nxt.xhi = xhi1_r;
    sb2_nxt.ylo = ylo1_r;
    sb2_nxt.yhi = yhi1_r;
    sb3_nxt     = sb2_r;
    sb3_nxt.d   = uxx2_r + uyy2_r;
    sb3_nxt.dc  = c12_r - c22_r;
    sb4_nxt     = sb3_r;
    sb4_nxt.nz  = (sb3_r.d != '0);
    sq0_nxt.disc     = disc6;
    sq0_nxt.rem      = '0;
    sq0_nxt.root     = '0;
    sq0_nxt.sb       = sb5_r;
    sq0_nxt.sb.meets = meets6;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      sqv_r <= '0;
      t1v_r <= 1'b0;
      t2v_r <= 1'b0;
      ov_r  <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      sqv_r <= {sqv_r[SQW-1:0], v5_r};
      t1v_r <= sqv_r[SQW];
      t2v_r <= t1v_r;
      ov_r  <= t2v_r;
    end
  end

  // front stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      ux1_r  <= bx_e - ax_e;
      uy1_r  <= by_e - ay_e;
      pax1_r <= ax_e - cx_e;
      pay1_r <= ay_e - cy_e;
      pbx1_r <= bx_e - cx_e;
      pby1_r <= by_e - cy_e;
      xlo1_r <= ((ax_e < bx_e) ? ax_e : bx_e) - cx_e;
      xhi1_r <= ((ax_e < bx_e) ? bx_e : ax_e) - cx_e;
      ylo1_r <= ((ay_e < by_e) ? ay_e : by_e) - cy_e;
      yhi1_r <= ((ay_e < by_e) ? by_e : ay_e) - cy_e;
      r1_r   <= in_circle_radius;
      // stage 2
      uxx2_r <= DW'(ux1_r * ux1_r);
      uyy2_r <= DW'(uy1_r * uy1_r);
      c12_r  <= CRW'(pax1_r * pby1_r);
      c22_r  <= CRW'(pbx1_r * pay1_r);
      rr2_r  <= RRW'(r1_r * r1_r);
      sb2_r  <= sb2_nxt;
      // stage 3
      rr3_r    <= rr2_r;
      sb3_r    <= sb3_nxt;
      // stage 4
      sb4_r    <= sb4_nxt;
      small4_r <= (dabs[CRW-1:SQW] == '0);
      dd4_r    <= DISW'(dabs[SQW-1:0] * dabs[SQW-1:0]);
      plo4_r   <= MW'(rr3_r * sb3_r.d[DLW-1:0]);
      phi4_r   <= MW'(rr3_r * sb3_r.d[DW-1:DLW]);
      // stage 5
      sb5_r    <= sb4_r;
      small5_r <= small4_r;
      dd5_r    <= dd4_r;
      rrd5_r   <= DISW'(plo4_r) + (DISW'(phi4_r) << DLW);
      // stage 6: discriminant into the root pipe
      sq_r[0]  <= sq0_nxt;
    end
  end

  // square root: one result bit per stage
  for (genvar i = 0; i < SQW; i++) begin : g_sq
    logic [REMW-1:0] remsh, trial;
    logic            ge;
    always_comb begin
      remsh = {sq_r[i].rem[REMW-3:0], sq_r[i].disc[DISW-1:DISW-2]};
      trial = REMW'({sq_r[i].root, 2'b01});
      ge    = (remsh >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[i+1] <= '{disc: sq_r[i].disc << 2,
                       rem:  ge ? (remsh - trial) : remsh,
                       root: {sq_r[i].root[SQW-2:0], ge},
                       sb:   sq_r[i].sb};
      end
    end
  end

  // back stages: numerators, box edges scaled by d, strict compare
  always_ff @(posedge clk) begin
    if (en) begin
      uxs1_r  <= PW'(sq_r[SQW].sb.ux * $signed({1'b0, sq_r[SQW].root}));
      auys1_r <= PW'((sq_r[SQW].sb.uy[UW-1] ? -sq_r[SQW].sb.uy : sq_r[SQW].sb.uy) *
                     $signed({1'b0, sq_r[SQW].root}));
      bxp1_r  <= PW'(sq_r[SQW].sb.dc * sq_r[SQW].sb.uy);
      dcux1_r <= PW'(sq_r[SQW].sb.dc * sq_r[SQW].sb.ux);
      dxlo1_r <= PW'($signed({1'b0, sq_r[SQW].sb.d}) * sq_r[SQW].sb.xlo);
      dxhi1_r <= PW'($signed({1'b0, sq_r[SQW].sb.d}) * sq_r[SQW].sb.xhi);
      dylo1_r <= PW'($signed({1'b0, sq_r[SQW].sb.d}) * sq_r[SQW].sb.ylo);
      dyhi1_r <= PW'($signed({1'b0, sq_r[SQW].sb.d}) * sq_r[SQW].sb.yhi);
      uyneg1_r <= sq_r[SQW].sb.uy[UW-1];
      flag1_r  <= sq_r[SQW].sb.meets && sq_r[SQW].sb.nz;
      meets1_r <= sq_r[SQW].sb.meets;
      n1x2_r  <= bxp1_r - ox;
      n1y2_r  <= by2 - oy;
      n2x2_r  <= bxp1_r + ox;
      n2y2_r  <= by2 + oy;
      dxlo2_r <= dxlo1_r;
      dxhi2_r <= dxhi1_r;
      dylo2_r <= dylo1_r;
      dyhi2_r <= dyhi1_r;
      flag2_r  <= flag1_r;
      meets2_r <= meets1_r;
      ohit_r   <= flag2_r && (in1 || in2);
      omeet_r  <= meets2_r;
    end
  end

  assign out_valid             = ov_r;
  assign out_hit               = ohit_r;
  assign out_line_meets_circle = omeet_r;

endmodule

// File: design/csi_checker.sv
// Port-level checker for circle_segment_intersection, bound to the top level.
// Does not depend on csi_pkg; all of its ports are single bits.
module csi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit,
  input logic out_line_meets_circle
);

  // no result word right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a held result word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
    $stable(out_line_meets_circle))
    else $error("held result word changed");

  // a hit needs the line to meet the circle
  a_hit_meets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_line_meets_circle)
    else $error("hit without line meeting circle");

  // input stalls only while a result word is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without held result word");

endmodule

bind circle_segment_intersection csi_checker u_csi_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_hit               (out_hit),
  .out_line_meets_circle (out_line_meets_circle)
);
